### sv/tce_pkg.sv
// Shared types, constants and helpers for the text console character engine.
// No dependencies; every other file except tce_ram imports this package.
package tce_pkg;

  // Screen storage limits
  localparam int MAX_COLS = 128;
  localparam int MAX_ROWS = 32;
  localparam int TAB_STEP = 4;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;

  // Field and register widths
  localparam int FLD_W    = 8;                            // column and row fields
  localparam int CHAR_W   = 8;
  localparam int OP_W     = 2;
  localparam int CFGC_W   = 8;                            // columns_in_use register
  localparam int CFGR_W   = 6;                            // rows_in_use register
  localparam int COL_W    = $clog2(MAX_COLS);             // on-screen column
  localparam int ROW_W    = $clog2(MAX_ROWS);             // on-screen row
  localparam int GW_W     = $clog2(MAX_COLS + 1);         // effective width
  localparam int GH_W     = $clog2(MAX_ROWS + 1);         // effective height
  localparam int CURC_W   = $clog2(MAX_COLS + TAB_STEP);  // cursor column before wrap
  localparam int CURR_W   = $clog2(MAX_ROWS + TAB_STEP + 1); // cursor row before scroll
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int AREA_W   = $clog2(CELLS + 1);
  localparam int SCR_W    = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SET   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // Control characters
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CODE_LINEFEED  = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_DELETE    = 8'd127;

  // Command kinds produced by the front end
  localparam logic [2:0] K_WRITE   = 3'd0;
  localparam logic [2:0] K_BACK    = 3'd1;
  localparam logic [2:0] K_TAB     = 3'd2;
  localparam logic [2:0] K_NEWLINE = 3'd3;
  localparam logic [2:0] K_DELETE  = 3'd4;
  localparam logic [2:0] K_SET     = 3'd5;
  localparam logic [2:0] K_CLEAR   = 3'd6;
  localparam logic [2:0] K_READ    = 3'd7;

  // Register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  typedef struct packed {
    logic [2:0]        kind;
    logic [CHAR_W-1:0] code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic [GW_W-1:0] w;
    logic [GH_W-1:0] h;
  } geom_t;

  typedef struct packed {
    logic init_busy;
  } be_stat_t;

  function automatic logic [GW_W-1:0] eff_cols(input logic [CFGC_W-1:0] v);
    if (v == '0) begin
      return GW_W'(1);
    end else if (GW_W'(v) > GW_W'(MAX_COLS)) begin
      return GW_W'(MAX_COLS);
    end
    return GW_W'(v);
  endfunction

  function automatic logic [GH_W-1:0] eff_rows(input logic [CFGR_W-1:0] v);
    if (v == '0) begin
      return GH_W'(1);
    end else if (GH_W'(v) > GH_W'(MAX_ROWS)) begin
      return GH_W'(MAX_ROWS);
    end
    return GH_W'(v);
  endfunction

endpackage

### sv/tce_ifs.sv
// Word channels of the console engine: request and response.
// Depends on tce_pkg for field widths.
interface tce_req_if import tce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [CHAR_W-1:0] char_code;
  logic [FLD_W-1:0]  column;
  logic [FLD_W-1:0]  row;

  modport source (output valid, operation, char_code, column, row, input ready);
  modport sink   (input valid, operation, char_code, column, row, output ready);
endinterface

interface tce_rsp_if import tce_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CHAR_W-1:0] cell_value;
  logic [SCR_W-1:0]  lines_scrolled;

  modport source (output valid, cursor_col, cursor_row, cell_value, lines_scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cell_value, lines_scrolled,
                  output ready);
endinterface

### sv/text_console_character_engine_unit.sv
// Top level of the text console character engine: configuration registers,
// front end, command queue and back end. Depends on tce_pkg, tce_ifs,
// tce_front, tce_queue, tce_back (and through it tce_ram).
//
// Character-cell text console. Each request word carries one operation (put
// character, set cursor, clear screen, read cell) and yields exactly one
// response word with the cursor after the operation, the cell read and the
// number of scroll steps taken. The store is a single 4096-byte RAM laid out
// row by row at column + row * width. A decoder in front accepts words into a
// two-deep command queue, so up to two words plus one waiting response can be
// in flight while the back end works. In the back end, set cursor and
// out-of-screen reads go straight to the response; cell reads pass through
// the access and read-wait states, written characters through access and the
// wrap state, which takes one step for each row the cursor wraps onto. Each
// scroll step walks the visible screen through the RAM one cell per cycle.
// Clear walks the whole store. After reset the same clearing pass runs with
// req.ready low; register writes are taken during it.
// Write the width and height registers only while no word is outstanding; the
// cursor is pulled into the new screen before the next word runs.
module text_console_character_engine_unit import tce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tce_req_if.sink     req,
  tce_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CFGC_W-1:0] columns_in_use;
  logic [CFGR_W-1:0] rows_in_use;
  logic              cfg_wr;
  geom_t             geom;
  be_stat_t          stat;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  cmd_t              cmd_in;
  cmd_t              cmd_out;

  // APB register file; word select on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= CFGC_W'(80);
      rows_in_use    <= CFGR_W'(25);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_COLS: columns_in_use <= pwdata[CFGC_W-1:0];
        REG_ROWS: rows_in_use    <= pwdata[CFGR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_COLS: prdata = 32'(columns_in_use);
      REG_ROWS: prdata = 32'(rows_in_use);
      default:  prdata = '0;
    endcase
  end

  // Effective screen size: zero reads as one, oversize clamps to the store
  assign geom.w = eff_cols(columns_in_use);
  assign geom.h = eff_rows(rows_in_use);

  tce_front u_front (
    .req    (req),
    .geom   (geom),
    .stat   (stat),
    .q_full (q_full),
    .push   (push),
    .cmd    (cmd_in)
  );

  tce_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (q_empty)
  );

  tce_back u_back (
    .clk     (clk),
    .rst     (rst),
    .geom    (geom),
    .q_empty (q_empty),
    .q_cmd   (cmd_out),
    .q_pop   (pop),
    .stat    (stat),
    .rsp     (rsp)
  );

  // No word enters while the post-reset sweep is running
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.init_busy |-> !req.ready)
    else $error("request accepted during store clearing pass");

  // A scroll always leaves the cursor on the bottom row
  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.lines_scrolled != '0) |->
      (GH_W'(rsp.cursor_row) == geom.h - 1'b1))
    else $error("scrolled response with cursor off the bottom row");

  // One word can push the cursor at most a tab step of rows past the screen
  a_scroll_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.lines_scrolled <= SCR_W'(TAB_STEP)))
    else $error("runaway scroll count");

endmodule

### sv/tce_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module tce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tce_front.sv
// Front end: accepts request words, decodes them into commands, clamps
// set-cursor targets and range-checks reads. Depends on tce_pkg, tce_ifs.
module tce_front import tce_pkg::*; (
  tce_req_if.sink  req,
  input  geom_t    geom,
  input  be_stat_t stat,
  input  logic     q_full,
  output logic     push,
  output cmd_t     cmd
);

  logic [FLD_W-1:0] w_f;
  logic [FLD_W-1:0] h_f;

  assign w_f = FLD_W'(geom.w);
  assign h_f = FLD_W'(geom.h);

  // Hold off while the store is being swept after reset
  assign req.ready = !q_full && !stat.init_busy;
  assign push      = req.valid && req.ready;

  always_comb begin
    cmd          = '0;
    cmd.code     = req.char_code;
    case (req.operation)
      OP_PUT: begin
        case (req.char_code)
          CODE_BACKSPACE: cmd.kind = K_BACK;
          CODE_TAB:       cmd.kind = K_TAB;
          CODE_LINEFEED:  cmd.kind = K_NEWLINE;
          CODE_RETURN:    cmd.kind = K_NEWLINE;
          CODE_DELETE:    cmd.kind = K_DELETE;
          default:        cmd.kind = K_WRITE;
        endcase
      end
      OP_SET: begin
        cmd.kind = K_SET;
        cmd.col  = (req.column >= w_f) ? COL_W'(w_f - 1'b1) : COL_W'(req.column);
        cmd.row  = (req.row >= h_f) ? ROW_W'(h_f - 1'b1) : ROW_W'(req.row);
      end
      OP_CLEAR: begin
        cmd.kind = K_CLEAR;
      end
      default: begin
        cmd.kind     = K_READ;
        cmd.in_range = (req.column < w_f) && (req.row < h_f);
        cmd.col      = COL_W'(req.column);
        cmd.row      = ROW_W'(req.row);
      end
    endcase
  end

endmodule

### sv/tce_queue.sv
// Short command queue between the front and back ends.
// Depends on tce_pkg for cmd_t and the queue depth.
module tce_queue import tce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t              slot [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign dout  = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/tce_back.sv
// Back end: cursor state, character store sequencing (write, read, wrap,
// scroll sweep, clear sweep) and the response register.
// Depends on tce_pkg, tce_ifs and tce_ram.
module tce_back import tce_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  geom_t     geom,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output be_stat_t  stat,
  tce_rsp_if.source rsp
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ACCESS = 3'd1;
  localparam logic [2:0] S_RWAIT  = 3'd2;
  localparam logic [2:0] S_WRAP   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_ZERO   = 3'd5;
  localparam logic [2:0] S_CLEAR  = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  localparam logic [SCR_W-1:0] SCR_MAX = '1;

  logic [2:0]        state;
  cmd_t              cmd_r;
  logic [CURC_W-1:0] cur_col;
  logic [CURR_W-1:0] cur_row;
  logic [ADDR_W-1:0] addr_r;
  logic [AREA_W-1:0] ix;
  logic              pend;
  logic [ADDR_W-1:0] pend_addr;
  logic [SCR_W-1:0]  scrolls;
  logic [CHAR_W-1:0] cell_code;
  logic              item;
  logic [AREA_W-1:0] area_m1;
  logic [AREA_W-1:0] area;

  logic [CURC_W-1:0] w_c;
  logic [CURR_W-1:0] h_r;
  logic [CURC_W-1:0] cc;
  logic [CURR_W-1:0] cr;
  logic [CURC_W-1:0] sel_col;
  logic [CURR_W-1:0] sel_row;
  logic [ADDR_W-1:0] addr_next;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CHAR_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [CHAR_W-1:0] rdata;

  tce_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign w_c = CURC_W'(geom.w);
  assign h_r = CURR_W'(geom.h);

  // Cursor as seen after any pending screen resize
  assign cc = (cur_col >= w_c) ? w_c - 1'b1 : cur_col;
  assign cr = (cur_row >= h_r) ? h_r - 1'b1 : cur_row;

  assign stat.init_busy = (state == S_CLEAR) && !item;
  assign q_pop          = (state == S_IDLE) && !q_empty;

  // Cell address for the popped command
  always_comb begin
    sel_col = cc;
    sel_row = cr;
    case (q_cmd.kind)
      K_DELETE: sel_col = cc - 1'b1;
      K_READ: begin
        sel_col = CURC_W'(q_cmd.col);
        sel_row = CURR_W'(q_cmd.row);
      end
      default: ;
    endcase
    addr_next = ADDR_W'(sel_row) * ADDR_W'(geom.w) + ADDR_W'(sel_col);
  end

  // Screen area products, stable while items run
  always_ff @(posedge clk) begin
    area_m1 <= AREA_W'(geom.h - 1'b1) * AREA_W'(geom.w);
    area    <= AREA_W'(geom.h) * AREA_W'(geom.w);
  end

  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    re    = 1'b0;
    raddr = addr_r;
    case (state)
      S_ACCESS: begin
        if (cmd_r.kind == K_READ) begin
          re = 1'b1;
        end else begin
          we    = 1'b1;
          wdata = (cmd_r.kind == K_WRITE) ? cmd_r.code : '0;
        end
      end
      S_SCROLL: begin
        re    = (ix < area_m1);
        raddr = ADDR_W'(ix + AREA_W'(geom.w));
        we    = pend;
        waddr = pend_addr;
        wdata = rdata;
      end
      S_ZERO, S_CLEAR: begin
        we    = 1'b1;
        waddr = ix[ADDR_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      item      <= 1'b0;
      ix        <= '0;
      pend      <= 1'b0;
      cur_col   <= '0;
      cur_row   <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_empty) begin
            cur_col <= cc;
            cur_row <= cr;
          end else begin
            cmd_r     <= q_cmd;
            addr_r    <= addr_next;
            scrolls   <= '0;
            cell_code <= '0;
            case (q_cmd.kind)
              K_WRITE: begin
                cur_col <= cc + 1'b1;
                cur_row <= cr;
                state   <= S_ACCESS;
              end
              K_DELETE: begin
                cur_row <= cr;
                if (cc != '0) begin
                  cur_col <= cc - 1'b1;
                  state   <= S_ACCESS;
                end else begin
                  cur_col <= cc;
                  state   <= S_WRAP;
                end
              end
              K_BACK: begin
                cur_col <= (cc != '0) ? cc - 1'b1 : cc;
                cur_row <= cr;
                state   <= S_WRAP;
              end
              K_TAB: begin
                cur_col <= cc + CURC_W'(TAB_STEP);
                cur_row <= cr;
                state   <= S_WRAP;
              end
              K_NEWLINE: begin
                cur_col <= '0;
                cur_row <= cr + 1'b1;
                state   <= S_WRAP;
              end
              K_SET: begin
                cur_col <= CURC_W'(q_cmd.col);
                cur_row <= CURR_W'(q_cmd.row);
                state   <= S_DONE;
              end
              K_CLEAR: begin
                cur_col <= '0;
                cur_row <= '0;
                ix      <= '0;
                item    <= 1'b1;
                state   <= S_CLEAR;
              end
              default: begin
                cur_col <= cc;
                cur_row <= cr;
                state   <= q_cmd.in_range ? S_ACCESS : S_DONE;
              end
            endcase
          end
        end
        S_ACCESS: begin
          state <= (cmd_r.kind == K_READ) ? S_RWAIT : S_WRAP;
        end
        S_RWAIT: begin
          cell_code <= rdata;
          state     <= S_DONE;
        end
        S_WRAP: begin
          if (cur_col >= w_c) begin
            cur_col <= cur_col - w_c;
            cur_row <= cur_row + 1'b1;
          end else if (cur_row >= h_r) begin
            ix    <= '0;
            pend  <= 1'b0;
            state <= S_SCROLL;
          end else begin
            state <= S_DONE;
          end
        end
        S_SCROLL: begin
          // Copy each cell up one row, one cell per cycle
          if (ix < area_m1) begin
            pend      <= 1'b1;
            pend_addr <= ADDR_W'(ix);
            ix        <= ix + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_ZERO;
            end
          end
        end
        S_ZERO: begin
          if (ix == area - AREA_W'(1)) begin
            cur_row <= cur_row - 1'b1;
            if (scrolls != SCR_MAX) begin
              scrolls <= scrolls + 1'b1;
            end
            state <= S_WRAP;
          end else begin
            ix <= ix + 1'b1;
          end
        end
        S_CLEAR: begin
          if (ix == AREA_W'(CELLS - 1)) begin
            state <= item ? S_DONE : S_IDLE;
          end else begin
            ix <= ix + 1'b1;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.cursor_col     <= cur_col[COL_W-1:0];
      rsp.cursor_row     <= cur_row[ROW_W-1:0];
      rsp.cell_value     <= cell_code;
      rsp.lines_scrolled <= scrolls;
    end
  end

endmodule
